[src/tsp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types, constants and note tables of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

    // classified request kinds passed from front to core
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_POST = 2'd1,
        OP_STOP = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // volume scale classes
    typedef enum logic [1:0] {
        SC_35  = 2'd0,
        SC_50  = 2'd1,
        SC_100 = 2'd2
    } t_scale;

    localparam logic [5:0] CODE_TERMINAL  = 6'd14;
    localparam logic [5:0] CODE_LAST      = 6'd38;
    localparam logic [5:0] SID_VARIANT0   = 6'd38;
    localparam logic [2:0] LEVEL_MUTE     = 3'd0;
    localparam logic [2:0] LEVEL_MAX      = 3'd5;
    localparam logic [2:0] VARIANT_LAST   = 3'd4;
    localparam logic [7:0] VAR_COUNT_LAST = 8'd255;

    typedef struct packed {
        t_op        op;
        logic [5:0] code;
        logic       prio;
    } t_cmd;

    typedef struct packed {
        logic        tone_start;
        logic [10:0] tone_freq;
        logic [9:0]  tone_length_ms;
        logic [7:0]  volume;
        logic        speaker_stop;
        logic        busy_res;
    } t_res;

    typedef struct packed {
        logic [10:0] freq;
        logic [9:0]  dur;
        logic [7:0]  pause;
    } t_step;

    function automatic t_step mk(input int f, input int d, input int p);
        t_step s;
        s.freq  = 11'(f);
        s.dur   = 10'(d);
        s.pause = 8'(p);
        return s;
    endfunction

    function automatic logic is_priority(input logic [5:0] code);
        logic r;
        r = 1'b0;
        case (code) inside
            6'd2, 6'd3, 6'd5, 6'd6, 6'd7, 6'd8, 6'd23: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_scale scale_of(input logic [5:0] code);
        t_scale r;
        r = SC_100;
        case (code) inside
            6'd34, 6'd36, 6'd37, 6'd38: r = SC_35;
            6'd1, 6'd4, 6'd12, 6'd14, 6'd18, 6'd35: r = SC_50;
            default: r = SC_100;
        endcase
        return r;
    endfunction

    // level map entry times scale over 100, precomputed
    function automatic logic [7:0] vol_of(input logic [2:0] lvl, input t_scale sc);
        logic [7:0] r;
        r = 8'd0;
        case (sc)
            SC_35: begin
                case (lvl)
                    3'd1: r = 8'd7;
                    3'd2: r = 8'd15;
                    3'd3: r = 8'd28;
                    3'd4: r = 8'd49;
                    3'd5: r = 8'd73;
                    default: r = 8'd0;
                endcase
            end
            SC_50: begin
                case (lvl)
                    3'd1: r = 8'd10;
                    3'd2: r = 8'd22;
                    3'd3: r = 8'd40;
                    3'd4: r = 8'd70;
                    3'd5: r = 8'd105;
                    default: r = 8'd0;
                endcase
            end
            default: begin
                case (lvl)
                    3'd1: r = 8'd20;
                    3'd2: r = 8'd45;
                    3'd3: r = 8'd80;
                    3'd4: r = 8'd140;
                    3'd5: r = 8'd210;
                    default: r = 8'd0;
                endcase
            end
        endcase
        return r;
    endfunction

    function automatic logic [3:0] seq_len(input logic [5:0] sid);
        logic [3:0] r;
        r = 4'd0;
        case (sid)
            6'd1: r = 4'd2;   6'd2: r = 4'd4;   6'd3: r = 4'd2;   6'd4: r = 4'd1;
            6'd5: r = 4'd3;   6'd6: r = 4'd4;   6'd7: r = 4'd4;   6'd8: r = 4'd5;
            6'd9: r = 4'd2;   6'd10: r = 4'd3;  6'd11: r = 4'd2;  6'd12: r = 4'd1;
            6'd13: r = 4'd1;  6'd14: r = 4'd2;  6'd15: r = 4'd14; 6'd16: r = 4'd10;
            6'd17: r = 4'd4;  6'd18: r = 4'd1;  6'd19: r = 4'd2;  6'd20: r = 4'd1;
            6'd21: r = 4'd2;  6'd22: r = 4'd3;  6'd23: r = 4'd5;  6'd24: r = 4'd12;
            6'd25: r = 4'd2;  6'd26: r = 4'd2;  6'd27: r = 4'd2;  6'd28: r = 4'd1;
            6'd29: r = 4'd1;  6'd30: r = 4'd5;  6'd31: r = 4'd4;  6'd32: r = 4'd5;
            6'd33: r = 4'd4;  6'd34: r = 4'd1;  6'd35: r = 4'd4;  6'd36: r = 4'd1;
            6'd37: r = 4'd3;  6'd38: r = 4'd3;  6'd39: r = 4'd2;  6'd40: r = 4'd2;
            6'd41: r = 4'd3;  6'd42: r = 4'd3;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    // note table; steps past a sequence's end read as zero
    function automatic t_step rom_step(input logic [5:0] sid, input logic [3:0] idx);
        t_step r;
        r = '0;
        case ({sid, idx})
            {6'd1, 4'd0}: r = mk(700, 18, 0);
            {6'd1, 4'd1}: r = mk(520, 14, 0);
            {6'd2, 4'd0}: r = mk(800, 60, 15);
            {6'd2, 4'd1}: r = mk(1000, 60, 15);
            {6'd2, 4'd2}: r = mk(1200, 80, 15);
            {6'd2, 4'd3}: r = mk(1000, 100, 0);
            {6'd3, 4'd0}: r = mk(1000, 50, 15);
            {6'd3, 4'd1}: r = mk(1300, 50, 0);
            {6'd4, 4'd0}: r = mk(820, 5, 0);
            {6'd5, 4'd0}: r = mk(600, 80, 25);
            {6'd5, 4'd1}: r = mk(900, 80, 25);
            {6'd5, 4'd2}: r = mk(1200, 100, 0);
            {6'd6, 4'd0}: r = mk(500, 80, 20);
            {6'd6, 4'd1}: r = mk(700, 80, 20);
            {6'd6, 4'd2}: r = mk(1000, 80, 20);
            {6'd6, 4'd3}: r = mk(1200, 120, 0);
            {6'd7, 4'd0}: r = mk(700, 50, 15);
            {6'd7, 4'd1}: r = mk(900, 50, 15);
            {6'd7, 4'd2}: r = mk(1100, 50, 15);
            {6'd7, 4'd3}: r = mk(1400, 100, 0);
            {6'd8, 4'd0}: r = mk(500, 60, 15);
            {6'd8, 4'd1}: r = mk(700, 60, 15);
            {6'd8, 4'd2}: r = mk(900, 60, 15);
            {6'd8, 4'd3}: r = mk(1100, 80, 20);
            {6'd8, 4'd4}: r = mk(1400, 150, 0);
            {6'd9, 4'd0}: r = mk(900, 80, 40);
            {6'd9, 4'd1}: r = mk(1100, 80, 0);
            {6'd10, 4'd0}: r = mk(800, 70, 20);
            {6'd10, 4'd1}: r = mk(1000, 70, 20);
            {6'd10, 4'd2}: r = mk(1200, 100, 0);
            {6'd11, 4'd0}: r = mk(330, 50, 20);
            {6'd11, 4'd1}: r = mk(250, 60, 0);
            {6'd12, 4'd0}: r = mk(1050, 6, 0);
            {6'd13, 4'd0}: r = mk(900, 7, 0);
            {6'd14, 4'd0}: r = mk(260, 12, 2);
            {6'd14, 4'd1}: r = mk(540, 3, 0);
            {6'd15, 4'd0}: r = mk(250, 650, 140);
            {6'd15, 4'd1}: r = mk(600, 12, 30);
            {6'd15, 4'd2}: r = mk(700, 12, 30);
            {6'd15, 4'd3}: r = mk(520, 12, 60);
            {6'd15, 4'd4}: r = mk(240, 180, 80);
            {6'd15, 4'd5}: r = mk(800, 12, 30);
            {6'd15, 4'd6}: r = mk(640, 12, 30);
            {6'd15, 4'd7}: r = mk(500, 12, 60);
            {6'd15, 4'd8}: r = mk(900, 10, 30);
            {6'd15, 4'd9}: r = mk(700, 10, 30);
            {6'd15, 4'd10}: r = mk(850, 10, 60);
            {6'd15, 4'd11}: r = mk(280, 230, 70);
            {6'd15, 4'd12}: r = mk(310, 320, 90);
            {6'd15, 4'd13}: r = mk(360, 360, 0);
            {6'd16, 4'd0}: r = mk(270, 480, 140);
            {6'd16, 4'd1}: r = mk(540, 12, 40);
            {6'd16, 4'd2}: r = mk(660, 12, 40);
            {6'd16, 4'd3}: r = mk(560, 12, 80);
            {6'd16, 4'd4}: r = mk(240, 160, 70);
            {6'd16, 4'd5}: r = mk(820, 10, 40);
            {6'd16, 4'd6}: r = mk(700, 10, 60);
            {6'd16, 4'd7}: r = mk(310, 210, 70);
            {6'd16, 4'd8}: r = mk(340, 220, 70);
            {6'd16, 4'd9}: r = mk(280, 240, 0);
            {6'd17, 4'd0}: r = mk(500, 35, 0);
            {6'd17, 4'd1}: r = mk(800, 35, 0);
            {6'd17, 4'd2}: r = mk(500, 35, 0);
            {6'd17, 4'd3}: r = mk(800, 35, 0);
            {6'd18, 4'd0}: r = mk(1000, 6, 0);
            {6'd19, 4'd0}: r = mk(800, 80, 25);
            {6'd19, 4'd1}: r = mk(500, 120, 0);
            {6'd20, 4'd0}: r = mk(900, 40, 0);
            {6'd21, 4'd0}: r = mk(700, 40, 15);
            {6'd21, 4'd1}: r = mk(1000, 50, 0);
            {6'd22, 4'd0}: r = mk(700, 60, 20);
            {6'd22, 4'd1}: r = mk(900, 60, 20);
            {6'd22, 4'd2}: r = mk(1100, 80, 0);
            {6'd23, 4'd0}: r = mk(800, 70, 20);
            {6'd23, 4'd1}: r = mk(1000, 70, 20);
            {6'd23, 4'd2}: r = mk(1200, 70, 20);
            {6'd23, 4'd3}: r = mk(1500, 100, 15);
            {6'd23, 4'd4}: r = mk(1200, 80, 0);
            {6'd24, 4'd0}: r = mk(220, 200, 20);
            {6'd24, 4'd1}: r = mk(344, 80, 0);
            {6'd24, 4'd2}: r = mk(356, 80, 0);
            {6'd24, 4'd3}: r = mk(344, 80, 0);
            {6'd24, 4'd4}: r = mk(356, 80, 0);
            {6'd24, 4'd5}: r = mk(494, 60, 0);
            {6'd24, 4'd6}: r = mk(344, 80, 0);
            {6'd24, 4'd7}: r = mk(356, 80, 0);
            {6'd24, 4'd8}: r = mk(622, 60, 0);
            {6'd24, 4'd9}: r = mk(348, 400, 0);
            {6'd24, 4'd10}: r = mk(260, 400, 0);
            {6'd24, 4'd11}: r = mk(220, 800, 0);
            {6'd25, 4'd0}: r = mk(700, 30, 10);
            {6'd25, 4'd1}: r = mk(1000, 40, 0);
            {6'd26, 4'd0}: r = mk(900, 30, 10);
            {6'd26, 4'd1}: r = mk(600, 40, 0);
            {6'd27, 4'd0}: r = mk(800, 40, 15);
            {6'd27, 4'd1}: r = mk(1100, 50, 0);
            {6'd28, 4'd0}: r = mk(1200, 4, 0);
            {6'd29, 4'd0}: r = mk(800, 25, 0);
            {6'd30, 4'd0}: r = mk(320, 30, 0);
            {6'd30, 4'd1}: r = mk(280, 25, 5);
            {6'd30, 4'd2}: r = mk(310, 20, 0);
            {6'd30, 4'd3}: r = mk(240, 30, 0);
            {6'd30, 4'd4}: r = mk(200, 25, 0);
            {6'd31, 4'd0}: r = mk(420, 40, 0);
            {6'd31, 4'd1}: r = mk(340, 35, 0);
            {6'd31, 4'd2}: r = mk(400, 20, 5);
            {6'd31, 4'd3}: r = mk(300, 40, 0);
            {6'd32, 4'd0}: r = mk(700, 25, 0);
            {6'd32, 4'd1}: r = mk(900, 25, 0);
            {6'd32, 4'd2}: r = mk(850, 20, 0);
            {6'd32, 4'd3}: r = mk(1100, 30, 0);
            {6'd32, 4'd4}: r = mk(1200, 35, 0);
            {6'd33, 4'd0}: r = mk(350, 25, 12);
            {6'd33, 4'd1}: r = mk(380, 20, 10);
            {6'd33, 4'd2}: r = mk(500, 35, 5);
            {6'd33, 4'd3}: r = mk(580, 40, 0);
            {6'd34, 4'd0}: r = mk(1000, 20, 0);
            {6'd35, 4'd0}: r = mk(280, 30, 0);
            {6'd35, 4'd1}: r = mk(350, 30, 0);
            {6'd35, 4'd2}: r = mk(500, 30, 0);
            {6'd35, 4'd3}: r = mk(700, 40, 0);
            {6'd36, 4'd0}: r = mk(600, 8, 0);
            {6'd37, 4'd0}: r = mk(1400, 25, 0);
            {6'd37, 4'd1}: r = mk(900, 35, 0);
            {6'd37, 4'd2}: r = mk(600, 20, 0);
            {6'd38, 4'd0}: r = mk(220, 60, 0);
            {6'd38, 4'd1}: r = mk(350, 25, 10);
            {6'd38, 4'd2}: r = mk(280, 20, 0);
            {6'd39, 4'd0}: r = mk(240, 13, 2);
            {6'd39, 4'd1}: r = mk(500, 3, 0);
            {6'd40, 4'd0}: r = mk(280, 11, 2);
            {6'd40, 4'd1}: r = mk(600, 3, 0);
            {6'd41, 4'd0}: r = mk(220, 14, 2);
            {6'd41, 4'd1}: r = mk(460, 3, 2);
            {6'd41, 4'd2}: r = mk(220, 10, 0);
            {6'd42, 4'd0}: r = mk(300, 10, 2);
            {6'd42, 4'd1}: r = mk(620, 3, 2);
            {6'd42, 4'd2}: r = mk(250, 12, 0);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

[src/tsp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_front
// Accepts requests, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module tsp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [1:0]        i_operation,
    input  logic [5:0]        i_event_code,
    output logic              o_cmd_valid,
    output tsp_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import tsp_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       cls;
    logic       wr_en;

    // classify the incoming request
    always_comb begin
        cls.code = i_event_code;
        cls.prio = is_priority(i_event_code);
        case (t_op'(i_operation))
            OP_TICK: cls.op = OP_TICK;
            OP_POST: cls.op = (i_event_code == 6'd0) ? OP_NONE : OP_POST;
            OP_STOP: cls.op = OP_STOP;
            default: cls.op = OP_NONE;
        endcase
    end

    assign full        = (r_cnt == 2'd2);
    assign wr_en       = push && !full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wp] <= cls;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) r_wp <= ~r_wp;
            if (i_cmd_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(wr_en) - 2'(i_cmd_take);
        end
    end

endmodule

[src/tsp_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_core
// Runs one classified request per cycle on i_fire: event ring, note sequencer.
// ----------------------------------------------------------------------------
module tsp_core #(
    parameter int QUEUE_DEPTH = 4,
    parameter int TIME_BITS   = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_data,
    input  logic              i_fire,
    input  tsp_pkg::t_cmd     i_cmd,
    output tsp_pkg::t_res     o_res
);
    import tsp_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam logic [PW-1:0] P_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [TIME_BITS-1:0] T_MAX = '1;

    logic [2:0]           r_level;
    logic [5:0]           r_ring [QUEUE_DEPTH];
    logic [PW-1:0]        r_wpos, r_rpos, n_wpos, n_rpos;
    logic                 r_active, n_active;
    logic [5:0]           r_sel, n_sel;
    logic [3:0]           r_idx, n_idx;
    logic [TIME_BITS-1:0] r_elapsed, n_elapsed;
    logic                 r_tone, n_tone;
    logic [7:0]           r_vcnt, n_vcnt;
    logic [2:0]           r_vmod, n_vmod;
    logic                 ring_we;
    logic [PW-1:0]        ring_wa;

    function automatic logic [PW-1:0] pnext(input logic [PW-1:0] p);
        return (p == P_LAST) ? '0 : p + 1'b1;
    endfunction

    logic [5:0]           head;
    logic [2:0]           lvl;
    logic [5:0]           sid;
    t_step                cur, nst, st0;
    logic [3:0]           nxt_idx;
    logic [TIME_BITS-1:0] el_inc;
    logic [PW-1:0]        pw, pr, pn;
    logic                 pa;

    assign head    = r_ring[r_rpos];
    assign lvl     = (r_level > LEVEL_MAX) ? LEVEL_MAX : r_level;
    assign cur     = rom_step(r_sel, r_idx);
    assign nxt_idx = r_idx + 4'd1;
    assign nst     = rom_step(r_sel, nxt_idx);
    assign el_inc  = (r_elapsed < T_MAX) ? r_elapsed + 1'b1 : r_elapsed;

    // terminal tick variant selection
    always_comb begin
        sid = head;
        if (head == CODE_TERMINAL && r_vmod != 3'd0) begin
            sid = SID_VARIANT0 + {3'd0, r_vmod};
        end
    end
    assign st0 = rom_step(sid, 4'd0);

    // next state and result
    always_comb begin
        n_wpos    = r_wpos;
        n_rpos    = r_rpos;
        n_active  = r_active;
        n_sel     = r_sel;
        n_idx     = r_idx;
        n_elapsed = r_elapsed;
        n_tone    = r_tone;
        n_vcnt    = r_vcnt;
        n_vmod    = r_vmod;
        ring_we   = 1'b0;
        ring_wa   = r_wpos;
        o_res     = '0;
        pa        = r_active;
        pw        = r_wpos;
        pr        = r_rpos;
        pn        = pnext(r_wpos);
        if (i_fire) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_level == LEVEL_MUTE) begin
                        n_wpos   = r_rpos;
                        n_active = 1'b0;
                    end else if (r_active) begin
                        if (r_idx >= seq_len(r_sel)) begin
                            // last step done a tick ago
                            n_active   = 1'b0;
                            n_idx      = 4'd0;
                            n_elapsed  = el_inc;
                            o_res.busy_res = (r_rpos != r_wpos);
                        end else begin
                            n_elapsed = el_inc;
                            o_res.busy_res = 1'b1;
                            if ((r_tone && el_inc >= TIME_BITS'(cur.dur) && cur.pause == 8'd0)
                                || (!r_tone && el_inc >= TIME_BITS'(cur.pause))) begin
                                // advance to next note
                                n_idx     = nxt_idx;
                                n_tone    = 1'b1;
                                n_elapsed = '0;
                                if (nst.freq != 11'd0 && nst.dur != 10'd0) begin
                                    o_res.tone_start     = 1'b1;
                                    o_res.tone_freq      = nst.freq;
                                    o_res.tone_length_ms = nst.dur;
                                end
                            end else if (r_tone && el_inc >= TIME_BITS'(cur.dur)) begin
                                // enter pause
                                n_tone    = 1'b0;
                                n_elapsed = '0;
                            end
                        end
                    end else if (r_rpos != r_wpos) begin
                        n_rpos = pnext(r_rpos);
                        if (head != 6'd0 && head <= CODE_LAST) begin
                            if (head == CODE_TERMINAL) begin
                                n_vcnt = r_vcnt + 8'd1;
                                n_vmod = (r_vcnt == VAR_COUNT_LAST || r_vmod == VARIANT_LAST)
                                         ? 3'd0 : r_vmod + 3'd1;
                            end
                            n_active             = 1'b1;
                            n_sel                = sid;
                            n_idx                = 4'd0;
                            n_elapsed            = '0;
                            n_tone               = 1'b1;
                            o_res.volume         = vol_of(lvl, scale_of(head));
                            o_res.tone_start     = 1'b1;
                            o_res.tone_freq      = st0.freq;
                            o_res.tone_length_ms = st0.dur;
                            o_res.busy_res       = 1'b1;
                        end else begin
                            o_res.busy_res = (pnext(r_rpos) != r_wpos);
                        end
                    end
                end
                OP_POST: begin
                    if (r_level != LEVEL_MUTE) begin
                        if (i_cmd.prio && r_active) begin
                            // priority cut-off
                            pa    = 1'b0;
                            n_idx = 4'd0;
                            pw    = '0;
                            pr    = '0;
                            pn    = pnext('0);
                            o_res.speaker_stop = 1'b1;
                        end
                        if (pn == pr) pr = pnext(pr);
                        ring_we  = 1'b1;
                        ring_wa  = pw;
                        n_wpos   = pn;
                        n_rpos   = pr;
                        n_active = pa;
                        o_res.busy_res = 1'b1;
                    end else begin
                        o_res.busy_res = r_active || (r_rpos != r_wpos);
                    end
                end
                OP_STOP: begin
                    n_active = 1'b0;
                    n_idx    = 4'd0;
                    n_wpos   = '0;
                    n_rpos   = '0;
                    o_res.speaker_stop = 1'b1;
                end
                default: begin
                    o_res.busy_res = r_active || (r_rpos != r_wpos);
                end
            endcase
        end
    end

    // event ring storage
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[ring_wa] <= i_cmd.code;
        end
    end

    // sequencer and ring control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level   <= 3'd3;
            r_wpos    <= '0;
            r_rpos    <= '0;
            r_active  <= 1'b0;
            r_sel     <= 6'd0;
            r_idx     <= 4'd0;
            r_elapsed <= '0;
            r_tone    <= 1'b0;
            r_vcnt    <= 8'd0;
            r_vmod    <= 3'd0;
        end else begin
            if (i_cfg_we) r_level <= i_cfg_data;
            r_wpos    <= n_wpos;
            r_rpos    <= n_rpos;
            r_active  <= n_active;
            r_sel     <= n_sel;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
            r_tone    <= n_tone;
            r_vcnt    <= n_vcnt;
            r_vmod    <= n_vmod;
        end
    end

endmodule

[src/tsp_resq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_resq
// Two-entry result queue between the core and the result ports.
// ----------------------------------------------------------------------------
module tsp_resq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  tsp_pkg::t_res     i_res,
    output logic              o_room,
    output logic              empty,
    input  logic              pop,
    output tsp_pkg::t_res     o_res
);
    import tsp_pkg::*;

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       rd_en;

    assign o_room = (r_cnt != 2'd2);
    assign empty  = (r_cnt == 2'd0);
    assign rd_en  = pop && !empty;
    assign o_res  = r_q[r_rp];

    // result storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) r_wp <= ~r_wp;
            if (rd_en) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_wr) - 2'(rd_en);
        end
    end

endmodule

[src/tone_sequence_player_with_event_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_sequence_player_with_event_queue
// Buzzer effect sequencer: event ring, note table player, tone commands.
// ----------------------------------------------------------------------------
// channel   | handshake           | payload
// request   | push / full         | i_operation, i_event_code
// result    | empty / pop         | o_tone_start .. o_busy_res
// config    | cfg_valid/cfg_ready | i_cfg_data (sound level)
//
// one request per cycle sustained while results are popped; a result reaches
// the ports via the front queue register, then the core into the result queue
// the core executes one request per cycle while the result queue has room;
// each side has a two-entry queue; synchronous active-low reset; config is
// always ready; a stalled result side fills both queues and then raises full
// ----------------------------------------------------------------------------
module tone_sequence_player_with_event_queue #(
    parameter int QUEUE_DEPTH = 4,
    parameter int TIME_BITS   = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [5:0]  i_event_code,
    output logic        empty,
    input  logic        pop,
    output logic        o_tone_start,
    output logic [10:0] o_tone_freq,
    output logic [9:0]  o_tone_length_ms,
    output logic [7:0]  o_volume,
    output logic        o_speaker_stop,
    output logic        o_busy_res,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  i_cfg_data
);
    import tsp_pkg::*;

    logic cmd_valid, room, fire;
    t_cmd cmd;
    t_res core_res, out_res;

    assign cfg_ready = 1'b1;
    assign fire      = cmd_valid && room;

    // front: accept and classify
    tsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_operation (i_operation),
        .i_event_code(i_event_code),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (fire)
    );

    // back: execute
    tsp_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH),
        .TIME_BITS  (TIME_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_valid && cfg_ready),
        .i_cfg_data(i_cfg_data),
        .i_fire    (fire),
        .i_cmd     (cmd),
        .o_res     (core_res)
    );

    // result queue
    tsp_resq u_resq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (fire),
        .i_res  (core_res),
        .o_room (room),
        .empty  (empty),
        .pop    (pop),
        .o_res  (out_res)
    );

    assign o_tone_start     = out_res.tone_start;
    assign o_tone_freq      = out_res.tone_freq;
    assign o_tone_length_ms = out_res.tone_length_ms;
    assign o_volume         = out_res.volume;
    assign o_speaker_stop   = out_res.speaker_stop;
    assign o_busy_res       = out_res.busy_res;

endmodule

[src/tsp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_checker
// Port-level checks of the tone sequence player, bound to the top level.
// ----------------------------------------------------------------------------
module tsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        o_tone_start,
    input logic [10:0] o_tone_freq,
    input logic [9:0]  o_tone_length_ms,
    input logic [7:0]  o_volume,
    input logic        o_speaker_stop
);

    // reset leaves both queues empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    // no tone command means zero tone fields
    a_tone_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_tone_start) |-> (o_tone_freq == 11'd0 && o_tone_length_ms == 10'd0))
        else $error("tone fields set without tone start");

    // a speaker stop carries no tone and no volume
    a_stop_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_speaker_stop) |-> (!o_tone_start && o_volume == 8'd0))
        else $error("speaker stop with tone or volume");

    // a sequence start always issues its first tone
    a_volume_tone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_volume != 8'd0) |-> (o_tone_start && o_tone_length_ms != 10'd0))
        else $error("volume without first tone");

endmodule

bind tone_sequence_player_with_event_queue tsp_checker u_tsp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .o_tone_start    (o_tone_start),
    .o_tone_freq     (o_tone_freq),
    .o_tone_length_ms(o_tone_length_ms),
    .o_volume        (o_volume),
    .o_speaker_stop  (o_speaker_stop)
);
